### sv/acet_pkg.sv
`default_nettype none

package acet_pkg;

	// Default number of bits in a collider id.
	localparam int ID_BITS_DEF = 6;

	// Fixed field widths of one input word.
	localparam int COORD_W = 16;
	localparam int SIZE_W  = 15;

	// Queue depths: classified pairs between front and back, and finished results.
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// Contact events as reported on event_res.
	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_ENTER = 2'd1,
		EV_STAY  = 2'd2,
		EV_EXIT  = 2'd3
	} acet_event_t;

	// Classification that the front hands to the back with each pair address.
	typedef struct packed {
		logic pair_ok;  // the two ids differ, so the contact bit takes part
		logic hit;      // the two boxes overlap
	} acet_cls_t;

endpackage

`default_nettype wire

### sv/aabb_contact_event_tracker_core.sv
// A pair accepted at a clock edge passes the front stage, the classified-pair queue and the contact bit
// read before its result reaches the head of the result queue.
// Throughput: one pair word per cycle while full is low, set by the memory's single read and write port.
// Reset: arst_n clears all control at once; then a clearing pass writes all 2^(2*ID_BITS) contact
// bits (4096 at the default), while full stays high.
`default_nettype none

module aabb_contact_event_tracker_core #(
	parameter int ID_BITS = acet_pkg::ID_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [ID_BITS-1:0]                  left_id,
	input  wire logic [ID_BITS-1:0]                  other_id,
	input  wire logic signed [acet_pkg::COORD_W-1:0] left_x,
	input  wire logic signed [acet_pkg::COORD_W-1:0] left_y,
	input  wire logic [acet_pkg::SIZE_W-1:0]         left_w,
	input  wire logic [acet_pkg::SIZE_W-1:0]         left_h,
	input  wire logic signed [acet_pkg::COORD_W-1:0] right_x,
	input  wire logic signed [acet_pkg::COORD_W-1:0] right_y,
	input  wire logic [acet_pkg::SIZE_W-1:0]         right_w,
	input  wire logic [acet_pkg::SIZE_W-1:0]         right_h,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [1:0]                               event_res,
	output logic                                     overlap
);

	import acet_pkg::*;

	// The contact memory holds one bit per ordered id pair, addressed by
	// {left_id, other_id}, so (a,b) and (b,a) are tracked separately.
	localparam int ADDR_W = 2 * ID_BITS;
	localparam int ITEM_W = ADDR_W + $bits(acet_cls_t);

	logic              busy;
	logic              mid_full;
	logic              mid_empty;
	logic              mid_push;
	logic [ADDR_W-1:0] mid_addr;
	acet_cls_t         mid_cls;
	logic [ITEM_W-1:0] mid_rdata;
	logic              mid_take;
	logic [ADDR_W-1:0] back_addr;
	acet_cls_t         back_cls;

	// The front takes in one word per cycle while full is low and works out the overlap
	// test on both axes. The result needs no stored state, so it is decided entirely here.
	acet_front #(
		.ID_BITS(ID_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.left_id (left_id),
		.other_id(other_id),
		.left_x  (left_x),
		.left_y  (left_y),
		.left_w  (left_w),
		.left_h  (left_h),
		.right_x (right_x),
		.right_y (right_y),
		.right_w (right_w),
		.right_h (right_h),
		.busy    (busy),
		.mid_full(mid_full),
		.mid_push(mid_push),
		.mid_addr(mid_addr),
		.mid_cls (mid_cls)
	);

	// A short queue of classified pairs lets the front keep accepting words while
	// the back waits on a full result queue, and the other way round.
	acet_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata ({mid_addr, mid_cls}),
		.full  (mid_full),
		.pop   (mid_take),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	assign back_addr = mid_rdata[ITEM_W-1:$bits(acet_cls_t)];
	assign back_cls  = acet_cls_t'(mid_rdata[$bits(acet_cls_t)-1:0]);

	// The back reads the contact bit of each pair, turns bit and overlap into an
	// enter, stay or exit event and writes the new bit. A pair whose ids are equal
	// reports no event and leaves its bit alone. The write of one pair is forwarded
	// to the next one when both address the same bit.
	acet_back #(
		.ID_BITS(ID_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_addr  (back_addr),
		.in_cls   (back_cls),
		.in_take  (mid_take),
		.busy     (busy),
		.empty    (empty),
		.pop      (pop),
		.event_res(event_res),
		.overlap  (overlap)
	);

endmodule

`default_nettype wire

### sv/acet_ram.sv
`default_nettype none

module acet_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/acet_fifo.sv
`default_nettype none

module acet_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// The surrounding logic must honor full and empty; a dropped word shows up here.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("word pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && empty) |-> (cnt_q == '0))
		else $error("queue count out of step with empty");
`endif

endmodule

`default_nettype wire

### sv/acet_front.sv
`default_nettype none

module acet_front #(
	parameter int ID_BITS = acet_pkg::ID_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [ID_BITS-1:0]            left_id,
	input  wire logic [ID_BITS-1:0]            other_id,
	input  wire logic signed [acet_pkg::COORD_W-1:0] left_x,
	input  wire logic signed [acet_pkg::COORD_W-1:0] left_y,
	input  wire logic [acet_pkg::SIZE_W-1:0]   left_w,
	input  wire logic [acet_pkg::SIZE_W-1:0]   left_h,
	input  wire logic signed [acet_pkg::COORD_W-1:0] right_x,
	input  wire logic signed [acet_pkg::COORD_W-1:0] right_y,
	input  wire logic [acet_pkg::SIZE_W-1:0]   right_w,
	input  wire logic [acet_pkg::SIZE_W-1:0]   right_h,
	input  wire logic                          busy,
	input  wire logic                          mid_full,
	output logic                               mid_push,
	output logic [2*ID_BITS-1:0]               mid_addr,
	output acet_pkg::acet_cls_t                mid_cls
);

	import acet_pkg::*;

	localparam int DIFF_W = COORD_W + 1;
	localparam int SUM_W  = SIZE_W + 1;
	localparam int CMP_W  = DIFF_W + 1;

	logic                     valid_s1;
	logic [2*ID_BITS-1:0]     addr_s1;
	logic                     pair_ok_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [SUM_W-1:0]         sx_s1, sy_s1;

	logic                     accept;
	logic [DIFF_W-1:0]        mag_x, mag_y;
	logic                     hit_x, hit_y;

	assign full   = busy || (valid_s1 && mid_full);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (mid_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Center distances and size sums, each one add wide.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= {left_id, other_id};
			pair_ok_s1 <= (left_id != other_id);
			dx_s1      <= DIFF_W'(right_x) - DIFF_W'(left_x);
			dy_s1      <= DIFF_W'(right_y) - DIFF_W'(left_y);
			sx_s1      <= SUM_W'(left_w) + SUM_W'(right_w);
			sy_s1      <= SUM_W'(left_h) + SUM_W'(right_h);
		end
	end

	// Overlap on an axis: twice the absolute distance strictly below the size sum.
	always_comb begin
		mag_x = dx_s1[DIFF_W-1] ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
		mag_y = dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);
		hit_x = {mag_x, 1'b0} < CMP_W'(sx_s1);
		hit_y = {mag_y, 1'b0} < CMP_W'(sy_s1);
	end

	assign mid_push        = valid_s1 && !mid_full;
	assign mid_addr        = addr_s1;
	assign mid_cls.pair_ok = pair_ok_s1;
	assign mid_cls.hit     = hit_x && hit_y;

endmodule

`default_nettype wire

### sv/acet_back.sv
`default_nettype none

module acet_back #(
	parameter int ID_BITS = acet_pkg::ID_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [2*ID_BITS-1:0] in_addr,
	input  wire acet_pkg::acet_cls_t  in_cls,
	output logic                      in_take,
	output logic                      busy,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [1:0]                event_res,
	output logic                      overlap
);

	import acet_pkg::*;

	localparam int ADDR_W = 2 * ID_BITS;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int RES_W  = $bits(acet_event_t) + 1;

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              valid_s2;
	logic [ADDR_W-1:0] addr_s2;
	acet_cls_t         cls_s2;
	logic              fwd_s2;
	logic              fwd_bit_s2;

	logic              fire_s2;
	logic              item_we;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_wdata;
	logic              ram_rdata;
	logic              old_bit;
	acet_event_t       ev;
	logic              ofifo_full;
	logic [RES_W-1:0]  ofifo_rdata;

	assign busy    = clr_busy_q;
	assign fire_s2 = valid_s2 && !ofifo_full;
	assign item_we = fire_s2 && cls_s2.pair_ok;
	assign in_take = in_valid && !clr_busy_q && (!valid_s2 || fire_s2);

	// The clearing pass owns the write port; no pair reaches this stage meanwhile.
	assign ram_we    = clr_busy_q || item_we;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s2;
	assign ram_wdata = clr_busy_q ? 1'b0 : cls_s2.hit;

	acet_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_contact (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_take),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			valid_s2   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (in_take) begin
				valid_s2 <= 1'b1;
			end else if (fire_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// A write in the same cycle as the read is missed by the memory; keep it aside.
	always_ff @(posedge clk) begin
		if (in_take) begin
			addr_s2    <= in_addr;
			cls_s2     <= in_cls;
			fwd_s2     <= item_we && (addr_s2 == in_addr);
			fwd_bit_s2 <= cls_s2.hit;
		end
	end

	assign old_bit = fwd_s2 ? fwd_bit_s2 : ram_rdata;

	always_comb begin
		ev = EV_NONE;
		if (cls_s2.pair_ok) begin
			if (cls_s2.hit) begin
				ev = old_bit ? EV_STAY : EV_ENTER;
			end else if (old_bit) begin
				ev = EV_EXIT;
			end
		end
	end

	acet_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fire_s2),
		.wdata ({ev, cls_s2.hit}),
		.full  (ofifo_full),
		.pop   (pop),
		.rdata (ofifo_rdata),
		.empty (empty)
	);

	assign event_res = ofifo_rdata[RES_W-1:1];
	assign overlap   = ofifo_rdata[0];

`ifndef NO_ASSERTIONS
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!valid_s2 && !in_take))
		else $error("pair in flight during the clearing pass");

	// Back-to-back pairs on one address must see the bit just written.
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s2 && cls_s2.pair_ok) |=>
		((valid_s2 && cls_s2.pair_ok && (addr_s2 == $past(addr_s2))) |->
		(old_bit == $past(cls_s2.hit))))
		else $error("contact bit not forwarded");
`endif

endmodule

`default_nettype wire
